// ===== sv/pbas_pkg.sv =====
// ----------------------------------------------------------------------------
// pbas_pkg: shared definitions for the packed bit array store
// Widths, sizes, per-width lookup tables and the queue entry type used by
// the front, the queue and the back of the store.
// ----------------------------------------------------------------------------
package pbas_pkg;

  // Sizes of the stored array.
  localparam int ENTRY_COUNT    = 4096;
  localparam int WORD_COUNT     = 1024;
  localparam int WORD_BITS      = 64;
  localparam int MAX_ENTRY_BITS = 16;

  // Field widths.
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 16;
  localparam int CFG_W   = 5;
  localparam int WADDR_W = $clog2(WORD_COUNT);
  localparam int SLOT_W  = $clog2(WORD_BITS);
  localparam int OFF_W   = $clog2(WORD_BITS);

  // Entries per word go up to 64, which needs seven bits.
  localparam int PW_W = $clog2(WORD_BITS) + 1;

  // The word index is idx * RECIP >> RECIP_SHIFT. With a 20-bit shift the
  // quotient is exact for every 12-bit index and every divisor up to 64.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = IDX_W + RECIP_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified access as it waits in the queue.
  typedef struct packed {
    logic               mode;
    logic               in_range;
    logic [WADDR_W-1:0] word;
    logic [SLOT_W-1:0]  slot;
    logic [VAL_W-1:0]   value;
  } item_t;

  // Access codes carried in the mode field.
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Clamp the programmed width into 1..MAX_ENTRY_BITS.
  function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] w;
    w = cfg;
    if (w == '0) begin
      w = CFG_W'(1);
    end
    if (w > CFG_W'(MAX_ENTRY_BITS)) begin
      w = CFG_W'(MAX_ENTRY_BITS);
    end
    return w;
  endfunction

  // Entries held in one word for a given width.
  function automatic logic [PW_W-1:0] per_word(input logic [CFG_W-1:0] w);
    logic [PW_W-1:0] d;
    case (w)
      5'd1:    d = 7'd64;
      5'd2:    d = 7'd32;
      5'd3:    d = 7'd21;
      5'd4:    d = 7'd16;
      5'd5:    d = 7'd12;
      5'd6:    d = 7'd10;
      5'd7:    d = 7'd9;
      5'd8:    d = 7'd8;
      5'd9:    d = 7'd7;
      5'd10:   d = 7'd6;
      5'd11:   d = 7'd5;
      5'd12:   d = 7'd5;
      default: d = 7'd4;
    endcase
    return d;
  endfunction

  // Rounded-up reciprocal of per_word(w), scaled by 2**RECIP_SHIFT.
  function automatic logic [RECIP_W-1:0] recip(input logic [CFG_W-1:0] w);
    logic [RECIP_W-1:0] m;
    case (w)
      5'd1:    m = 19'd16384;
      5'd2:    m = 19'd32768;
      5'd3:    m = 19'd49933;
      5'd4:    m = 19'd65536;
      5'd5:    m = 19'd87382;
      5'd6:    m = 19'd104858;
      5'd7:    m = 19'd116509;
      5'd8:    m = 19'd131072;
      5'd9:    m = 19'd149797;
      5'd10:   m = 19'd174763;
      5'd11:   m = 19'd209716;
      5'd12:   m = 19'd209716;
      default: m = 19'd262144;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/pbas_front.sv =====
// ----------------------------------------------------------------------------
// pbas_front: access intake and address split
// Takes one access word, splits the entry index into word address and slot
// within the word, and pushes it into the queue.
// ----------------------------------------------------------------------------
module pbas_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pbas_pkg::CFG_W-1:0]    width,
  input  logic                          busy,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [pbas_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [pbas_pkg::VAL_W-1:0]    in_write_value,
  input  logic                          q_full,
  output logic                          push,
  output pbas_pkg::item_t               push_item
);

  localparam int QD_W = pbas_pkg::QUO_W + pbas_pkg::PW_W;

  logic                         f1_valid_r, f1_valid_nxt;
  logic                         f1_mode_r;
  logic [pbas_pkg::IDX_W-1:0]   f1_idx_r;
  logic [pbas_pkg::VAL_W-1:0]   f1_val_r;
  logic [pbas_pkg::QUO_W-1:0]   f1_quo_r, f1_quo_nxt;
  logic [pbas_pkg::PROD_W-1:0]  quo_prod;
  logic [QD_W-1:0]              qd_prod;
  logic [QD_W-1:0]              rem;
  logic                         accept;

  // Input handshake: hold off during the clearing pass or when stage one is stuck.
  assign in_stall = busy || (f1_valid_r && q_full);
  assign accept   = in_valid && !in_stall;
  assign push     = f1_valid_r && !q_full;

  // Word address by multiplying with the scaled reciprocal of entries per word.
  assign quo_prod   = pbas_pkg::PROD_W'(in_entry_index)
                    * pbas_pkg::PROD_W'(pbas_pkg::recip(width));
  assign f1_quo_nxt = quo_prod[pbas_pkg::PROD_W-1:pbas_pkg::RECIP_SHIFT];

  // Stage one valid tracks accepted words until they reach the queue.
  always_comb begin
    f1_valid_nxt = f1_valid_r;
    if (accept) begin
      f1_valid_nxt = 1'b1;
    end else if (push) begin
      f1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
    end
    if (accept) begin
      f1_mode_r <= in_mode;
      f1_idx_r  <= in_entry_index;
      f1_val_r  <= in_write_value;
      f1_quo_r  <= f1_quo_nxt;
    end
  end

  // Slot within the word is the remainder of the exact division.
  assign qd_prod = QD_W'(f1_quo_r) * QD_W'(pbas_pkg::per_word(width));
  assign rem     = QD_W'(f1_idx_r) - qd_prod;

  // Build the queue entry, flagging words beyond the array.
  always_comb begin
    push_item.mode     = f1_mode_r;
    push_item.in_range = (f1_quo_r < pbas_pkg::QUO_W'(pbas_pkg::WORD_COUNT));
    push_item.word     = pbas_pkg::WADDR_W'(f1_quo_r);
    push_item.slot     = pbas_pkg::SLOT_W'(rem);
    push_item.value    = f1_val_r;
  end

endmodule

// ===== sv/pbas_queue.sv =====
// ----------------------------------------------------------------------------
// pbas_queue: small queue between front and back
// Holds classified accesses so that intake and memory work stall on their own.
// ----------------------------------------------------------------------------
module pbas_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pbas_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output pbas_pkg::item_t  head_item
);

  pbas_pkg::item_t                 entries_r [pbas_pkg::QUEUE_DEPTH];
  logic [pbas_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [pbas_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [pbas_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full       = (count_r == pbas_pkg::QCNT_W'(pbas_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entries_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      if (wr_ptr_r == pbas_pkg::QPTR_W'(pbas_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
    end
    if (pop) begin
      if (rd_ptr_r == pbas_pkg::QPTR_W'(pbas_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_nxt = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue pop while empty");

  // The fill count stays within the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pbas_pkg::QCNT_W'(pbas_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== sv/pbas_back.sv =====
// ----------------------------------------------------------------------------
// pbas_back: memory sequencer
// Clears the word memory after reset, then runs each queued access as a
// read of the word followed by a field extract on a read or a masked merge and write-back on a write.
// ----------------------------------------------------------------------------
module pbas_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pbas_pkg::CFG_W-1:0]  width,
  output logic                        busy,
  input  logic                        q_valid,
  input  pbas_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pbas_pkg::VAL_W-1:0]  out_read_value
);

  localparam int MPROD_W = pbas_pkg::SLOT_W + pbas_pkg::CFG_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } state_t;

  state_t                             state_r, state_nxt;
  logic [pbas_pkg::WADDR_W-1:0]       clr_addr_r, clr_addr_nxt;
  pbas_pkg::item_t                    cur_item_r, cur_item_nxt;
  logic [pbas_pkg::OFF_W-1:0]         off_r, off_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [pbas_pkg::VAL_W-1:0]         out_value_r, out_value_nxt;

  logic [pbas_pkg::WORD_BITS-1:0]     mem [pbas_pkg::WORD_COUNT];
  logic [pbas_pkg::WORD_BITS-1:0]     mem_rdata_r;
  logic                               mem_we;
  logic                               mem_re;
  logic [pbas_pkg::WADDR_W-1:0]       mem_waddr;
  logic [pbas_pkg::WORD_BITS-1:0]     mem_wdata;

  logic [MPROD_W-1:0]                 off_prod;
  logic [pbas_pkg::VAL_W-1:0]         mask;
  logic [pbas_pkg::WORD_BITS-1:0]     field_mask;
  logic [pbas_pkg::WORD_BITS-1:0]     merged;
  logic [pbas_pkg::VAL_W-1:0]         field;
  logic                               out_free;

  assign busy           = (state_r == ST_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_free       = !out_valid_r || !out_stall;

  // Bit offset of the slot, taken when the access leaves the queue.
  assign off_prod = MPROD_W'(q_item.slot) * MPROD_W'(width);

  // Field mask, merged word and extracted field for the current access.
  assign mask       = pbas_pkg::VAL_W'(((pbas_pkg::VAL_W + 1)'(1) << width)
                    - (pbas_pkg::VAL_W + 1)'(1));
  assign field_mask = pbas_pkg::WORD_BITS'(mask) << off_r;
  assign merged     = (mem_rdata_r & ~field_mask)
                    | (pbas_pkg::WORD_BITS'(cur_item_r.value & mask) << off_r);
  assign field      = pbas_pkg::VAL_W'(mem_rdata_r >> off_r) & mask;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cur_item_nxt  = cur_item_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cur_item_r.word;
    mem_wdata     = merged;
    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == pbas_pkg::WADDR_W'(pbas_pkg::WORD_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          mem_re       = 1'b1;
          cur_item_nxt = q_item;
          off_nxt      = pbas_pkg::OFF_W'(off_prod);
          state_nxt    = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (out_free) begin
          mem_we        = (cur_item_r.mode == pbas_pkg::MODE_WRITE) && cur_item_r.in_range;
          out_valid_nxt = 1'b1;
          if ((cur_item_r.mode == pbas_pkg::MODE_READ) && cur_item_r.in_range) begin
            out_value_nxt = field;
          end else begin
            out_value_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_item_r  <= cur_item_nxt;
    off_r       <= off_nxt;
    out_value_r <= out_value_nxt;
  end

  // Word memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[q_item.word];
    end
  end

`ifndef SYNTHESIS
  // Nothing leaves the queue while the clearing pass runs.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !q_pop) else $error("queue pop during clearing pass");

  // A popped access enters the modify state in the very next cycle.
  a_pop_to_modify: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_MODIFY)) else $error("pop not followed by modify");

  // A result word appears only as a modify step completes.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_MODIFY))
    else $error("result without a modify step");

  // A write access always reports zero.
  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODIFY && out_free && cur_item_r.mode == pbas_pkg::MODE_WRITE)
    |=> (out_value_r == '0)) else $error("write reported nonzero value");
`endif

endmodule

// ===== sv/packed_bit_array_store.sv =====
// ----------------------------------------------------------------------------
// packed_bit_array_store: packed bit field array
// Top level: configuration register, access front end, queue and memory back.
// ----------------------------------------------------------------------------
// The store holds 4096 entries of 1 to 16 bits packed into 1024 words of 64
// bits, floor(64/width) entries per word, none spanning two words. Each input
// word reads or writes one entry and yields exactly one result word: the field
// on a read, zero on a write. After reset a clearing pass zeroes every word
// of the memory with in_stall high; configuration writes are taken at any
// time but the width must only change while the store is idle. The back end
// sequences each access as a word read, then a field extract on a read or a
// merge and write-back on a write, and takes no new access from the queue
// until the current one has completed.
module packed_bit_array_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pbas_pkg::CFG_W-1:0]  cfg_entry_bits,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [pbas_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [pbas_pkg::VAL_W-1:0]  in_write_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pbas_pkg::VAL_W-1:0]  out_read_value
);

  logic [pbas_pkg::CFG_W-1:0]  entry_bits_r, entry_bits_nxt;
  logic [pbas_pkg::CFG_W-1:0]  width;
  logic                        busy;
  logic                        push;
  logic                        q_full;
  logic                        q_valid;
  logic                        q_pop;
  pbas_pkg::item_t             push_item;
  pbas_pkg::item_t             q_item;

  // Width register, always ready to take a write.
  assign cfg_ready      = 1'b1;
  assign entry_bits_nxt = (cfg_valid && cfg_ready) ? cfg_entry_bits : entry_bits_r;
  assign width          = pbas_pkg::clamp_width(entry_bits_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_bits_r <= pbas_pkg::CFG_W'(4);
    end else begin
      entry_bits_r <= entry_bits_nxt;
    end
  end

  // Intake and address split.
  pbas_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .width          (width),
    .busy           (busy),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_write_value (in_write_value),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  // Queue between the two sides.
  pbas_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  // Memory sequencer and result register.
  pbas_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .width          (width),
    .busy           (busy),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value)
  );

endmodule

// ===== tb/packed_store_checker.sv =====
// ----------------------------------------------------------------------------
// packed_store_checker: result checker for the packed bit array store
// Watches the configuration, input and result channels of the store. It keeps
// its own copy of the packed words and the entry width, works out the field
// that each accepted access must return, and compares every result word in
// order. It reports a running mismatch count and the number of outstanding
// accesses to the testbench top.
// ----------------------------------------------------------------------------
module packed_store_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [pbas_pkg::CFG_W-1:0] cfg_entry_bits,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_mode,
  input  logic [pbas_pkg::IDX_W-1:0] in_entry_index,
  input  logic [pbas_pkg::VAL_W-1:0] in_write_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [pbas_pkg::VAL_W-1:0] out_read_value,
  output int unsigned                fail_count,
  output int unsigned                pending
);

  // One accepted access and the field it has to return.
  typedef struct packed {
    logic                       mode;
    logic [pbas_pkg::IDX_W-1:0] index;
    logic [pbas_pkg::VAL_W-1:0] value;
    logic [pbas_pkg::CFG_W-1:0] width;
    logic [pbas_pkg::VAL_W-1:0] field;
  } access_t;

  logic [pbas_pkg::WORD_BITS-1:0] shadow_words [pbas_pkg::WORD_COUNT];
  logic [pbas_pkg::CFG_W-1:0]     width_reg;
  access_t                        field_q [$];
  int unsigned                    mismatches = 0;

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one access to the shadow words and return the field it yields.
  function automatic logic [pbas_pkg::VAL_W-1:0] access_entry(
    input logic                       mode,
    input logic [pbas_pkg::IDX_W-1:0] idx,
    input logic [pbas_pkg::VAL_W-1:0] val
  );
    int unsigned                    w;
    int unsigned                    per;
    int unsigned                    word;
    int unsigned                    off;
    logic [pbas_pkg::WORD_BITS-1:0] mask;
    logic [pbas_pkg::VAL_W-1:0]     field;
    // A width of zero behaves as one, anything above the maximum as the maximum.
    w = width_reg;
    if (w < 1) begin
      w = 1;
    end
    if (w > pbas_pkg::MAX_ENTRY_BITS) begin
      w = pbas_pkg::MAX_ENTRY_BITS;
    end
    per   = pbas_pkg::WORD_BITS / w;
    word  = idx / per;
    off   = (idx % per) * w;
    mask  = (64'd1 << w) - 64'd1;
    field = '0;
    if (idx < pbas_pkg::ENTRY_COUNT && word < pbas_pkg::WORD_COUNT) begin
      if (mode == pbas_pkg::MODE_WRITE) begin
        shadow_words[word] = (shadow_words[word] & ~(mask << off)) |
                             ((64'(val) & mask) << off);
      end else begin
        field = 16'((shadow_words[word] >> off) & mask);
      end
    end
    return field;
  endfunction

  // Track the channels at each rising edge: results first, then new accesses.
  always @(posedge clk) begin
    access_t acc;
    if (!rst_n) begin
      foreach (shadow_words[i]) begin
        shadow_words[i] = '0;
      end
      width_reg = 5'd4;
      field_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        width_reg = cfg_entry_bits;
      end
      if (out_valid && !out_stall) begin
        if (field_q.size() == 0) begin
          report_mismatch($sformatf("result word 0x%04h with no access outstanding",
                                    out_read_value));
        end else begin
          acc = field_q.pop_front();
          if (out_read_value !== acc.field) begin
            report_mismatch($sformatf(
              "%s index %0d width %0d value 0x%04h: read_value 0x%04h, wanted 0x%04h",
              (acc.mode == pbas_pkg::MODE_WRITE) ? "write" : "read", acc.index,
              acc.width, acc.value, out_read_value, acc.field));
          end
        end
      end
      if (in_valid && !in_stall) begin
        acc.mode  = in_mode;
        acc.index = in_entry_index;
        acc.value = in_write_value;
        acc.width = width_reg;
        acc.field = access_entry(in_mode, in_entry_index, in_write_value);
        field_q.push_back(acc);
      end
    end
    pending    <= field_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_packed_bit_array_store.sv =====
// ----------------------------------------------------------------------------
// tb_packed_bit_array_store: testbench top for the packed bit array store
// Drives a directed set of accesses at the edge indexes and widths, then
// random phases of reads and writes over a series of entry widths, with
// random idle gaps on the input, random stalls on the result side, one long
// result hold-off and full drains between phases. A checker beside the block
// predicts and compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_packed_bit_array_store;

  typedef enum int {RX_FREE, RX_RANDOM, RX_HOLD} rx_style_t;

  // Entry widths of the random phases, phase 0 in the lowest five bits.
  localparam logic [59:0] WIDTH_PLAN = {5'd9, 5'd0, 5'd13, 5'd3, 5'd17, 5'd12,
                                        5'd2, 5'd31, 5'd5, 5'd16, 5'd8, 5'd1};
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_CYCLES = 150;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [pbas_pkg::CFG_W-1:0] cfg_entry_bits;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_mode;
  logic [pbas_pkg::IDX_W-1:0] in_entry_index;
  logic [pbas_pkg::VAL_W-1:0] in_write_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [pbas_pkg::VAL_W-1:0] out_read_value;
  int unsigned                fail_count;
  int unsigned                pending;

  rx_style_t                  rx_style = RX_FREE;
  bit                         gaps_on = 1'b0;
  logic [pbas_pkg::CFG_W-1:0] width_now = 5'd4;
  int unsigned                reads_sent = 0;
  int unsigned                writes_sent = 0;
  int unsigned                widths_set = 0;

  always #2 clk = ~clk;

  packed_bit_array_store dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_entry_bits (cfg_entry_bits),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value)
  );

  packed_store_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_entry_bits (cfg_entry_bits),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Offer one access word and hold it until accepted, then maybe idle.
  task automatic send_access(input logic                       mode,
                             input logic [pbas_pkg::IDX_W-1:0] idx,
                             input logic [pbas_pkg::VAL_W-1:0] val);
    int gap;
    int r;
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= idx;
    in_write_value <= val;
    do @(posedge clk); while (in_stall);
    if (mode == pbas_pkg::MODE_WRITE) begin
      writes_sent++;
    end else begin
      reads_sent++;
    end
    // Mostly back to back, some short gaps, a few long ones.
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 90) begin
        gap = $urandom_range(5, 40);
      end else if (r >= 60) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid       <= 1'b0;
      in_mode        <= 1'($urandom);
      in_entry_index <= 12'($urandom);
      in_write_value <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering words and wait until every result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Program the entry width once the store is idle.
  task automatic program_width(input logic [pbas_pkg::CFG_W-1:0] bits);
    drain_results();
    cfg_valid      <= 1'b1;
    cfg_entry_bits <= bits;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_now = bits;
    widths_set++;
  endtask

  // Pick an index: near a hot spot, on a word boundary, an end, or anywhere.
  function automatic logic [pbas_pkg::IDX_W-1:0] pick_index(
    input logic [pbas_pkg::IDX_W-1:0] hot
  );
    int r;
    int w;
    int per;
    int e;
    r = $urandom_range(0, 99);
    w = (width_now == 0) ? 1 : (width_now > 16) ? 16 : int'(width_now);
    per = 64 / w;
    if (r < 45) begin
      return hot + 12'($urandom_range(0, 47));
    end else if (r < 65) begin
      e = $urandom_range(0, 4096 / per) * per;
      if ($urandom_range(0, 1) == 1) begin
        e = e - 1;
      end
      if (e < 0) begin
        e = 0;
      end
      if (e > 4095) begin
        e = 4095;
      end
      return 12'(e);
    end else if (r < 72) begin
      return ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0;
    end
    return 12'($urandom);
  endfunction

  // Result side: stalls at random, or none, or one long hold-off.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_style == RX_HOLD) begin
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        rx_style = RX_RANDOM;
      end else if (rx_style == RX_FREE) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #3000000;
    $display("[packed_bit_array_store] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [pbas_pkg::IDX_W-1:0] hot;
    logic [pbas_pkg::VAL_W-1:0] val;
    int r;
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_entry_bits <= '0;
    in_valid       <= 1'b0;
    in_mode        <= pbas_pkg::MODE_READ;
    in_entry_index <= '0;
    in_write_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: cleared reads, both ends, dropped value bits, word edges.
    send_access(pbas_pkg::MODE_READ, 12'd0, 16'h0000);
    send_access(pbas_pkg::MODE_READ, 12'd4095, 16'hFFFF);
    send_access(pbas_pkg::MODE_WRITE, 12'd0, 16'hFFFF);
    send_access(pbas_pkg::MODE_WRITE, 12'd4095, 16'hFFFF);
    send_access(pbas_pkg::MODE_WRITE, 12'd1, 16'h0005);
    send_access(pbas_pkg::MODE_READ, 12'd0, 16'h0000);
    send_access(pbas_pkg::MODE_READ, 12'd1, 16'h0000);
    send_access(pbas_pkg::MODE_READ, 12'd4095, 16'h0000);
    send_access(pbas_pkg::MODE_WRITE, 12'd15, 16'hABCD);
    send_access(pbas_pkg::MODE_WRITE, 12'd16, 16'h1234);
    send_access(pbas_pkg::MODE_READ, 12'd15, 16'h0000);
    send_access(pbas_pkg::MODE_READ, 12'd16, 16'h0000);

    // A width of zero behaves as a width of one.
    program_width(5'd0);
    send_access(pbas_pkg::MODE_WRITE, 12'd4095, 16'hFFFE);
    send_access(pbas_pkg::MODE_READ, 12'd4095, 16'h0000);
    send_access(pbas_pkg::MODE_WRITE, 12'd63, 16'hFFFF);
    send_access(pbas_pkg::MODE_READ, 12'd63, 16'h0000);
    send_access(pbas_pkg::MODE_READ, 12'd64, 16'h0000);

    // A width above sixteen behaves as sixteen.
    program_width(5'd31);
    send_access(pbas_pkg::MODE_WRITE, 12'd4095, 16'hFFFF);
    send_access(pbas_pkg::MODE_READ, 12'd4095, 16'h0000);
    send_access(pbas_pkg::MODE_WRITE, 12'd3, 16'h8001);
    send_access(pbas_pkg::MODE_READ, 12'd3, 16'h0000);
    send_access(pbas_pkg::MODE_READ, 12'd4, 16'h0000);

    // Three-bit entries leave the top bit of each word unused.
    program_width(5'd3);
    send_access(pbas_pkg::MODE_WRITE, 12'd20, 16'hFFFF);
    send_access(pbas_pkg::MODE_WRITE, 12'd21, 16'hFFFF);
    send_access(pbas_pkg::MODE_READ, 12'd20, 16'h0000);
    send_access(pbas_pkg::MODE_READ, 12'd21, 16'h0000);

    // Random phases, one entry width each.
    for (int p = 0; p < PHASES; p++) begin
      program_width(WIDTH_PLAN[5*p +: 5]);
      rx_style = (p % 4 == 1) ? RX_FREE : RX_RANDOM;
      gaps_on  = (p % 3 != 2);
      hot      = 12'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the results off for a long stretch while words keep coming.
        if (p == 6 && i == 40) begin
          rx_style = RX_HOLD;
          gaps_on  = 1'b0;
        end
        if (p == 6 && i == 70) begin
          gaps_on = 1'b1;
        end
        // Pause the input until everything has come back.
        if (p == 8 && i == 55) begin
          drain_results();
        end
        r = $urandom_range(0, 99);
        val = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
        send_access(($urandom_range(0, 1) == 1) ? pbas_pkg::MODE_WRITE
                                                : pbas_pkg::MODE_READ,
                    pick_index(hot), val);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d reads and %0d writes over %0d entry width settings, widths 0 to 31.",
             reads_sent, writes_sent, widths_set);
    $display("Input gaps, result stalls, a long result hold-off and full drains were applied.");
    if (fail_count == 0 && pending == 0) begin
      $display("[packed_bit_array_store] OK");
    end else begin
      $display("[packed_bit_array_store] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pbas_pkg.sv
sv/pbas_front.sv
sv/pbas_queue.sv
sv/pbas_back.sv
sv/packed_bit_array_store.sv
tb/packed_store_checker.sv
tb/tb_packed_bit_array_store.sv
